/* src/flrm_pkg.sv */
// ----------------------------------------------------------------------------
// Fire loop resistance monitor package
// Shared types, register indexes, status codes and arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none

package flrm_pkg;

    // Loop status codes.
    localparam logic [1:0] STAT_OFF  = 2'd0;
    localparam logic [1:0] STAT_OK   = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;
    localparam logic [1:0] STAT_FIRE = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_MV = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY_MV    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SERIES_OHMS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_OHMS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_OHMS   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_JUMP_OHMS    = 3'd5;

    // Field widths.
    localparam int CODE_W   = 12;
    localparam int SUPPLY_W = 13;
    localparam int SERIES_W = 20;
    localparam int OHMS_W   = 24;

    // Shared divider: dividend up to series_ohms * millivolts, divisor up to supply.
    localparam int DIV_N_W = 33;
    localparam int DIV_D_W = 13;

    localparam logic [OHMS_W-1:0] OHMS_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [3:0]        channel;
        logic [CODE_W-1:0] sample_code;
        logic [CODE_W-1:0] vref_code;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        channel_out;
        logic [1:0]        loop_status;
        logic              announce;
        logic [OHMS_W-1:0] resistance_ohms;
    } out_item_t;

    // Per-channel state word.
    typedef struct packed {
        logic [1:0]        status;
        logic [OHMS_W-1:0] last_ohms;
        logic              first;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{status: STAT_OFF, last_ohms: '0, first: 1'b1};

    typedef struct packed {
        entry_t entry;
        logic   announce;
    } rule_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

/* src/flrm_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module flrm_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/flrm_div.sv */
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle; a one-cycle done pulse ends a run.
// ----------------------------------------------------------------------------
`default_nettype none

module flrm_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [flrm_pkg::DIV_N_W-1:0] dividend,
    input  wire logic [flrm_pkg::DIV_D_W-1:0] divisor,
    output flrm_pkg::div_stat_t               stat,
    output logic      [flrm_pkg::DIV_N_W-1:0] quotient
);

    localparam int N_W   = flrm_pkg::DIV_N_W;
    localparam int D_W   = flrm_pkg::DIV_D_W;
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [D_W:0] partial;
    logic [D_W:0] diff;
    logic         ge;

    always_comb
    begin
        partial = {rem_reg, quo_reg[N_W-1]};
        ge      = (partial >= {1'b0, div_reg});
        diff    = partial - {1'b0, div_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_W'(N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[N_W-2:0], ge};
            rem_next = ge ? diff[D_W-1:0] : partial[D_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* src/flrm_rules.sv */
// ----------------------------------------------------------------------------
// Loop status rules
// Applies the ordered status rules to one channel's stored state.
// ----------------------------------------------------------------------------
`default_nettype none

module flrm_rules (
    input  wire logic [flrm_pkg::OHMS_W-1:0] ohms,
    input  wire flrm_pkg::entry_t            prev,
    input  wire logic [flrm_pkg::OHMS_W-1:0] upper_ohms,
    input  wire logic [flrm_pkg::OHMS_W-1:0] lower_ohms,
    input  wire logic [flrm_pkg::OHMS_W-1:0] jump_ohms,
    output flrm_pkg::rule_out_t              result
);

    localparam int W = flrm_pkg::OHMS_W;

    logic [W-1:0] rise;
    logic [W-1:0] fall;
    logic         jump_up;
    logic         jump_down;
    logic         above_upper;
    logic         in_band;
    logic         below_lower;
    logic         is_ok;
    logic         is_bad;
    logic         is_off;
    logic         is_fire;
    logic [1:0]   diag;

    always_comb
    begin
        rise        = ohms - prev.last_ohms;
        fall        = prev.last_ohms - ohms;
        jump_up     = (ohms > prev.last_ohms) && (rise > jump_ohms);
        jump_down   = (prev.last_ohms > ohms) && (fall > jump_ohms);
        above_upper = ohms > upper_ohms;
        below_lower = ohms < lower_ohms;
        in_band     = (ohms < upper_ohms) && (ohms > lower_ohms);
        is_ok       = prev.status == flrm_pkg::STAT_OK;
        is_bad      = prev.status == flrm_pkg::STAT_BAD;
        is_off      = prev.status == flrm_pkg::STAT_OFF;
        is_fire     = prev.status == flrm_pkg::STAT_FIRE;
        diag        = in_band ? flrm_pkg::STAT_OK : flrm_pkg::STAT_BAD;

        result.entry.status    = prev.status;
        result.entry.last_ohms = ohms;
        result.entry.first     = prev.first;
        result.announce        = 1'b0;

        if (jump_up && (is_ok || is_bad))
        begin
            result.entry.status = flrm_pkg::STAT_OFF;
            result.announce     = 1'b1;
        end
        else if (above_upper && !is_fire)
        begin
            // Open loop keeps its status.
        end
        else if (in_band && is_ok)
        begin
            // Healthy loop keeps its status.
        end
        else if (jump_down && is_off && (ohms != '0) && (prev.last_ohms != '0))
        begin
            result.entry.status = diag;
            result.announce     = 1'b1;
        end
        else if (is_ok && below_lower)
        begin
            result.entry.status = flrm_pkg::STAT_FIRE;
            result.announce     = 1'b1;
        end
        else if (prev.first && !is_fire)
        begin
            result.entry.first  = 1'b0;
            result.entry.status = diag;
            result.announce     = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* src/fire_loop_resistance_monitor.sv */
// ----------------------------------------------------------------------------
// Fire loop resistance monitor
// Converts sensor ADC samples to loop resistance and tracks per-channel status.
// ----------------------------------------------------------------------------
// Each input item carries one channel's sensor code and the reference code.
// The block turns them into loop millivolts, then loop ohms, and updates that
// channel's status (off, ok, bad, fire) with an announce flag on changes that
// need a notification. One result item is returned for every input item. Each
// item passes the sequencer states idle, first multiply, first division,
// second multiply, second division and rule; the two divisions are two passes
// through one shared bit-serial divider of 33 quotient bits each. An item with
// a zero reference code skips both divisions and goes straight to the rule
// step, and one whose voltage is at or above the supply skips the second
// division. The block takes no new item until the current one has been handed
// to the output register, which can hold a finished result while the downstream
// side stalls. Per-channel state lives in a small RAM with one valid bit per
// channel, so it is ready right after reset with no clearing pass. Channel
// numbers at or beyond CHANNELS return status off and no announce, with the
// computed resistance, and leave all state untouched. Configuration is meant
// to be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fire_loop_resistance_monitor #(
    parameter int CHANNELS = 16,
    parameter int ADC_BITS = 12
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire flrm_pkg::in_item_t                 in_item,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output flrm_pkg::out_item_t                     out_item,
    input  wire logic                               cfg_write,
    input  wire logic [flrm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [flrm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CODE_W   = flrm_pkg::CODE_W;
    localparam int SUPPLY_W = flrm_pkg::SUPPLY_W;
    localparam int SERIES_W = flrm_pkg::SERIES_W;
    localparam int OHMS_W   = flrm_pkg::OHMS_W;
    localparam int N_W      = flrm_pkg::DIV_N_W;
    localparam int ENTRY_W  = $bits(flrm_pkg::entry_t);

    // Only the low ADC_BITS bits of each code are significant.
    localparam logic [CODE_W-1:0] ADC_MASK =
        (ADC_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((1 << ADC_BITS) - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_DIV1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_DIV2 = 3'd4;
    localparam logic [2:0] ST_RULE = 3'd5;

    // Configuration registers.
    logic [CODE_W-1:0]   ref_mv_reg;
    logic [SUPPLY_W-1:0] supply_mv_reg;
    logic [SERIES_W-1:0] series_reg;
    logic [OHMS_W-1:0]   upper_reg;
    logic [OHMS_W-1:0]   lower_reg;
    logic [OHMS_W-1:0]   jump_reg;

    // Sequencer and working registers.
    logic [2:0]          state_reg, state_next;
    logic [3:0]          ch_reg, ch_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [CODE_W-1:0]   vref_reg, vref_next;
    logic [SUPPLY_W-1:0] u_reg, u_next;
    logic [OHMS_W-1:0]   r_reg, r_next;
    logic                out_valid_reg, out_valid_next;
    flrm_pkg::out_item_t out_item_reg, out_item_next;
    logic [CHANNELS-1:0] entry_valid_reg, entry_valid_next;

    // Divider hookup.
    logic                         div_start;
    logic [N_W-1:0]               div_dividend;
    logic [flrm_pkg::DIV_D_W-1:0] div_divisor;
    flrm_pkg::div_stat_t          div_stat;
    logic [N_W-1:0]               div_quotient;

    // Channel state storage.
    logic                 accept;
    logic [CH_W+3:0]      in_ch_ext;
    logic [CH_W+3:0]      ch_ext;
    logic [CH_W-1:0]      rd_addr;
    logic [CH_W-1:0]      ch_idx;
    logic                 ch_in_range;
    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_rd_data;
    flrm_pkg::entry_t     prev_entry;
    flrm_pkg::rule_out_t  rule_result;

    logic [2*CODE_W-1:0]  volt_product;
    logic [N_W-1:0]       ohm_product;
    logic                 out_free;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign in_ch_ext   = {{CH_W{1'b0}}, in_item.channel};
    assign rd_addr     = in_ch_ext[CH_W-1:0];
    assign ch_ext      = {{CH_W{1'b0}}, ch_reg};
    assign ch_idx      = ch_ext[CH_W-1:0];
    assign ch_in_range = (32'(ch_reg) < CHANNELS);

    // A channel never written since reset reads as its reset state.
    assign prev_entry = entry_valid_reg[ch_idx] ? flrm_pkg::entry_t'(ram_rd_data)
                                                : flrm_pkg::ENTRY_RESET;

    // One multiplier shape per division; each product is registered by the divider.
    assign volt_product = {{CODE_W{1'b0}}, ref_mv_reg} * {{CODE_W{1'b0}}, code_reg};
    assign ohm_product  = N_W'(series_reg) * N_W'(u_reg);

    assign ram_we = (state_reg == ST_RULE) && out_free && ch_in_range;

    flrm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ch_idx),
        .wr_data (ENTRY_W'(rule_result.entry)),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    flrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    flrm_rules u_rules (
        .ohms       (r_reg),
        .prev       (prev_entry),
        .upper_ohms (upper_reg),
        .lower_ohms (lower_reg),
        .jump_ohms  (jump_reg),
        .result     (rule_result)
    );

    // Sequencer: millivolts by the first division, ohms by the second, then rules.
    always_comb
    begin
        state_next       = state_reg;
        ch_next          = ch_reg;
        code_next        = code_reg;
        vref_next        = vref_reg;
        u_next           = u_reg;
        r_next           = r_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_item_next    = out_item_reg;
        entry_valid_next = entry_valid_reg;
        div_start        = 1'b0;
        div_dividend     = N_W'(volt_product);
        div_divisor      = {1'b0, vref_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ch_next    = in_item.channel;
                    code_next  = in_item.sample_code & ADC_MASK;
                    vref_next  = in_item.vref_code & ADC_MASK;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                if (vref_reg == '0)
                begin
                    r_next     = flrm_pkg::OHMS_MAX;
                    state_next = ST_RULE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_stat.done)
                begin
                    // Voltage at or above the supply means an open loop.
                    if (div_quotient >= N_W'(supply_mv_reg))
                    begin
                        r_next     = flrm_pkg::OHMS_MAX;
                        state_next = ST_RULE;
                    end
                    else
                    begin
                        u_next     = div_quotient[SUPPLY_W-1:0];
                        state_next = ST_MUL2;
                    end
                end
            end
            ST_MUL2:
            begin
                div_start    = 1'b1;
                div_dividend = ohm_product;
                div_divisor  = supply_mv_reg - u_reg;
                state_next   = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (div_stat.done)
                begin
                    if (div_quotient[N_W-1:OHMS_W] != '0)
                    begin
                        r_next = flrm_pkg::OHMS_MAX;
                    end
                    else
                    begin
                        r_next = div_quotient[OHMS_W-1:0];
                    end
                    state_next = ST_RULE;
                end
            end
            ST_RULE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.channel_out     = ch_reg;
                    out_item_next.resistance_ohms = r_reg;
                    if (ch_in_range)
                    begin
                        out_item_next.loop_status = rule_result.entry.status;
                        out_item_next.announce    = rule_result.announce;
                        entry_valid_next[ch_idx]  = 1'b1;
                    end
                    else
                    begin
                        out_item_next.loop_status = flrm_pkg::STAT_OFF;
                        out_item_next.announce    = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        code_reg     <= code_next;
        vref_reg     <= vref_next;
        u_reg        <= u_next;
        r_reg        <= r_next;
        out_item_reg <= out_item_next;
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_mv_reg    <= CODE_W'(1200);
            supply_mv_reg <= SUPPLY_W'(3300);
            series_reg    <= SERIES_W'(10000);
            upper_reg     <= OHMS_W'(20000);
            lower_reg     <= OHMS_W'(2000);
            jump_reg      <= OHMS_W'(5000);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                flrm_pkg::REG_REFERENCE_MV: ref_mv_reg    <= cfg_data[CODE_W-1:0];
                flrm_pkg::REG_SUPPLY_MV:    supply_mv_reg <= cfg_data[SUPPLY_W-1:0];
                flrm_pkg::REG_SERIES_OHMS:  series_reg    <= cfg_data[SERIES_W-1:0];
                flrm_pkg::REG_UPPER_OHMS:   upper_reg     <= cfg_data[OHMS_W-1:0];
                flrm_pkg::REG_LOWER_OHMS:   lower_reg     <= cfg_data[OHMS_W-1:0];
                flrm_pkg::REG_JUMP_OHMS:    jump_reg      <= cfg_data[OHMS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fire loop resistance monitor testbench
// Drives sensor samples, predicts every result item and checks it on arrival.
// ----------------------------------------------------------------------------
// The testbench keeps its own copy of the per-channel loop state and of the
// six configuration registers. It works out the loop resistance, the new
// status and the announce flag for each input item at the moment the item is
// accepted, and it queues that expectation. A separate checker compares each
// result item with the oldest queued expectation. The run starts with short
// directed tests of the status rules and the register extremes. A backpressure
// test and about six hundred random items under changing register values and
// idle patterns follow.
// ----------------------------------------------------------------------------

module testbench;

    import flrm_pkg::*;

    localparam int NUM_CHANNELS = 16;

    // An index past the end of the register list. Writes to it must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_INDEX = 3'd6;

    localparam int LONG_STALL_CYCLES        = 400;
    localparam int QUIET_LIMIT              = 4000;
    localparam int DRAIN_CYCLES             = 150;
    localparam int RANDOM_ITEMS_PER_SETTING = 100;

    // One complete set of values for the configuration registers.
    typedef struct {
        logic [CFG_DATA_W-1:0] reference_mv;
        logic [CFG_DATA_W-1:0] supply_mv;
        logic [CFG_DATA_W-1:0] series_ohms;
        logic [CFG_DATA_W-1:0] upper_ohms;
        logic [CFG_DATA_W-1:0] lower_ohms;
        logic [CFG_DATA_W-1:0] jump_ohms;
    } loop_setting_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_item;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_item;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Idle percentages of the sender and the receiver, changed per phase.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // Raised by a test to make the receiver hold off for a long stretch.
    logic        stall_request;
    int unsigned error_count;
    int unsigned quiet_cycles;

    // Results still owed by the block, oldest first.
    out_item_t   pending_results[$];

    // Shadow copy of the configuration registers, starting from their reset values.
    logic [11:0]     shadow_reference_mv = 12'd1200;
    logic [12:0]     shadow_supply_mv    = 13'd3300;
    logic [19:0]     shadow_series_ohms  = 20'd10000;
    logic [OHMS_W-1:0] shadow_upper_ohms = 24'd20000;
    logic [OHMS_W-1:0] shadow_lower_ohms = 24'd2000;
    logic [OHMS_W-1:0] shadow_jump_ohms  = 24'd5000;

    // Shadow copy of the per-channel loop state.
    logic [1:0]        loop_status_of[NUM_CHANNELS];
    logic [OHMS_W-1:0] last_ohms_of[NUM_CHANNELS];
    logic              awaiting_first[NUM_CHANNELS];

    fire_loop_resistance_monitor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Loop voltage first, then loop resistance. A zero reference code or a
    // voltage at or above the supply drives the resistance to full scale.
    function automatic logic [OHMS_W-1:0] loop_ohms_from(input logic [CODE_W-1:0] code,
                                                        input logic [CODE_W-1:0] vref);
        logic [63:0] millivolts;
        logic [63:0] ohms;
        if (vref == '0)
            return OHMS_MAX;
        millivolts = (64'(shadow_reference_mv) * 64'(code)) / 64'(vref);
        if (millivolts >= 64'(shadow_supply_mv))
            return OHMS_MAX;
        ohms = (64'(shadow_series_ohms) * millivolts) / (64'(shadow_supply_mv) - millivolts);
        if (ohms > 64'(OHMS_MAX))
            return OHMS_MAX;
        return ohms[OHMS_W-1:0];
    endfunction

    // A diagnosis calls the loop ok only strictly between the two bounds.
    function automatic logic [1:0] diagnosed_status(input logic [OHMS_W-1:0] ohms);
        if (ohms < shadow_upper_ohms && ohms > shadow_lower_ohms)
            return STAT_OK;
        return STAT_BAD;
    endfunction

    // Works out the result of one accepted sample and moves the shadow state on.
    // The rules are tried in order and the first one that matches decides.
    function automatic out_item_t predict_loop_result(input in_item_t sample);
        out_item_t         result;
        logic [OHMS_W-1:0] ohms;
        logic [OHMS_W-1:0] prev;
        logic [1:0]        status;
        logic              notify;
        longint            rise;
        longint            jump;
        ohms = loop_ohms_from(sample.sample_code, sample.vref_code);
        result.channel_out     = sample.channel;
        result.resistance_ohms = ohms;
        result.loop_status     = STAT_OFF;
        result.announce        = 1'b0;
        // A channel past the end of the table leaves all state alone.
        if (int'(sample.channel) >= NUM_CHANNELS)
            return result;
        prev   = last_ohms_of[sample.channel];
        status = loop_status_of[sample.channel];
        notify = 1'b0;
        rise   = longint'(ohms) - longint'(prev);
        jump   = longint'(shadow_jump_ohms);
        if (rise > jump && (status == STAT_OK || status == STAT_BAD))
        begin
            // Sudden rise: the loop has come open.
            status = STAT_OFF;
            notify = 1'b1;
        end
        else if (ohms > shadow_upper_ohms && status != STAT_FIRE)
        begin
            // Open loop, nothing changes.
        end
        else if (ohms < shadow_upper_ohms && ohms > shadow_lower_ohms
                 && status == STAT_OK)
        begin
            // Healthy loop that stays healthy.
        end
        else if (-rise > jump && status == STAT_OFF && ohms != '0 && prev != '0)
        begin
            // Sudden drop on an open loop: it has been reconnected.
            status = diagnosed_status(ohms);
            notify = 1'b1;
        end
        else if (status == STAT_OK && ohms < shadow_lower_ohms)
        begin
            status = STAT_FIRE;
            notify = 1'b1;
        end
        else if (awaiting_first[sample.channel] && status != STAT_FIRE)
        begin
            awaiting_first[sample.channel] = 1'b0;
            status = diagnosed_status(ohms);
            notify = 1'b1;
        end
        loop_status_of[sample.channel] = status;
        last_ohms_of[sample.channel]   = ohms;
        result.loop_status = status;
        result.announce    = notify;
        return result;
    endfunction

    // Mirrors one register write. Indexes past the list are dropped.
    function automatic void shadow_register_write(input logic [CFG_INDEX_W-1:0] index,
                                                  input logic [CFG_DATA_W-1:0] value);
        case (index)
            REG_REFERENCE_MV: shadow_reference_mv = value[11:0];
            REG_SUPPLY_MV:    shadow_supply_mv    = value[12:0];
            REG_SERIES_OHMS:  shadow_series_ohms  = value[19:0];
            REG_UPPER_OHMS:   shadow_upper_ohms   = value[OHMS_W-1:0];
            REG_LOWER_OHMS:   shadow_lower_ohms   = value[OHMS_W-1:0];
            REG_JUMP_OHMS:    shadow_jump_ohms    = value[OHMS_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Offers one sample and returns at the edge where it is accepted. Valid is
    // left high on return: the next call either drops it for an idle gap or
    // puts the next sample on the bus at that same edge, so nothing is offered
    // twice.
    task automatic send_sample(input logic [3:0] channel, input logic [CODE_W-1:0] code,
                               input logic [CODE_W-1:0] vref);
        in_item_t sample;
        sample.channel     = channel;
        sample.sample_code = code;
        sample.vref_code   = vref;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_loop_result(sample));
    endtask

    // Drops valid and waits until every expected result item has arrived.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Leaves the write enable high; the caller lowers it after its last write.
    task automatic put_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        shadow_register_write(index, value);
    endtask

    // Writes all six registers while the block is idle, plus one write to an
    // index past the list that must have no effect.
    task automatic program_setting(input loop_setting_t setting);
        wait_until_idle();
        put_register(REG_REFERENCE_MV, setting.reference_mv);
        put_register(REG_SUPPLY_MV, setting.supply_mv);
        put_register(REG_SERIES_OHMS, setting.series_ohms);
        put_register(REG_UPPER_OHMS, setting.upper_ohms);
        put_register(REG_LOWER_OHMS, setting.lower_ohms);
        put_register(REG_JUMP_OHMS, setting.jump_ohms);
        put_register(REG_UNUSED_INDEX, CFG_DATA_W'($urandom));
        cfg_write <= 1'b0;
    endtask

    // Values close to a real installation, so that samples land on all sides
    // of the healthy band and the rules get exercised in depth.
    function automatic loop_setting_t realistic_setting();
        loop_setting_t setting;
        setting.reference_mv = CFG_DATA_W'($urandom_range(1400, 1000));
        setting.supply_mv    = CFG_DATA_W'($urandom_range(3600, 2800));
        setting.series_ohms  = CFG_DATA_W'($urandom_range(20000, 4000));
        setting.upper_ohms   = CFG_DATA_W'($urandom_range(40000, 12000));
        setting.lower_ohms   = CFG_DATA_W'($urandom_range(4000, 0));
        setting.jump_ohms    = CFG_DATA_W'($urandom_range(9000, 1000));
        return setting;
    endfunction

    // Any bit pattern at all in every register.
    function automatic loop_setting_t wild_setting();
        loop_setting_t setting;
        setting.reference_mv = CFG_DATA_W'($urandom_range(4095));
        setting.supply_mv    = CFG_DATA_W'($urandom_range(8191));
        setting.series_ohms  = CFG_DATA_W'($urandom_range(1048575));
        setting.upper_ohms   = CFG_DATA_W'($urandom_range(16777215));
        setting.lower_ohms   = CFG_DATA_W'($urandom_range(16777215));
        setting.jump_ohms    = CFG_DATA_W'($urandom_range(16777215));
        return setting;
    endfunction

    // Fire latches for good, so random traffic mostly goes to channels that
    // can still change state.
    function automatic logic [3:0] pick_channel();
        logic [3:0] open_channels[$];
        for (int c = 0; c < NUM_CHANNELS; c++)
            if (loop_status_of[c] != STAT_FIRE)
                open_channels.push_back(4'(c));
        if (open_channels.size() != 0 && $urandom_range(99) < 85)
            return open_channels[$urandom_range(open_channels.size() - 1)];
        return 4'($urandom_range(NUM_CHANNELS - 1));
    endfunction

    // With the reference near its code, the loop voltage in millivolts is about
    // the sample code, so the code bands below aim at a healthy loop, an open
    // loop and a shorted one. The rest is a zero reference or raw noise.
    task automatic send_random_sample();
        logic [3:0]        channel;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] vref;
        int unsigned       kind;
        channel = pick_channel();
        vref    = CODE_W'($urandom_range(1300, 1100));
        kind    = $urandom_range(99);
        if (kind < 58)
            code = CODE_W'($urandom_range(2150, 600));
        else if (kind < 78)
            code = CODE_W'($urandom_range(4095, 2300));
        else if (kind < 82)
            code = CODE_W'($urandom_range(500, 0));
        else if (kind < 88)
        begin
            code = CODE_W'($urandom_range(4095));
            vref = '0;
        end
        else
        begin
            code = CODE_W'($urandom_range(4095));
            vref = CODE_W'($urandom_range(4095));
        end
        send_sample(channel, code, vref);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walks the status rules under the reset values. With a reference code of
    // 1200 the loop voltage equals the sample code in millivolts.
    task automatic test_default_rules();
        // First sample of a healthy loop, then it stays healthy.
        send_sample(4'd0, 12'd1100, 12'd1200);
        send_sample(4'd0, 12'd1150, 12'd1200);
        // The loop comes open, then is reconnected and diagnosed again.
        send_sample(4'd0, 12'd3000, 12'd1200);
        send_sample(4'd0, 12'd1100, 12'd1200);
        // A drop below the lower bound raises fire, which then holds on
        // through a healthy sample and a saturated one.
        send_sample(4'd0, 12'd300, 12'd1200);
        send_sample(4'd0, 12'd1100, 12'd1200);
        send_sample(4'd0, 12'd3300, 12'd1200);
        // Zero reference code saturates; an open first sample keeps the
        // first-sample flag, so the later short still gets its diagnosis.
        send_sample(4'd1, 12'd2000, 12'd0);
        send_sample(4'd1, 12'd0, 12'd100);
        send_sample(4'd1, 12'd4095, 12'd1);
        // Full-scale codes on both inputs, and a small step on a bad loop.
        send_sample(4'd15, 12'd4095, 12'd4095);
        send_sample(4'd4, 12'd100, 12'd1200);
        send_sample(4'd4, 12'd1100, 12'd1200);
        send_sample(4'd10, 12'd2000, 12'd1200);
    endtask

    // Every register at its largest and smallest value. A zero supply makes
    // every voltage reach the supply, so everything saturates.
    task automatic test_register_extremes();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        program_setting('{24'd4095, 24'd8191, 24'hFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
        send_sample(4'd5, 12'd4095, 12'd4095);
        send_sample(4'd5, 12'd1, 12'd4095);
        send_sample(4'd6, 12'd4095, 12'd1);
        program_setting('{24'd4095, 24'd8191, 24'hFFFFF, 24'hFFFFFF, 24'd0, 24'd0});
        send_sample(4'd7, 12'd2048, 12'd4095);
        send_sample(4'd7, 12'd0, 12'd4095);
        program_setting('{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
        send_sample(4'd8, 12'd0, 12'd4095);
        send_sample(4'd8, 12'd4095, 12'd1);
        program_setting('{24'd4095, 24'd1, 24'hFFFFF, 24'd20000, 24'd2000, 24'd5000});
        send_sample(4'd9, 12'd0, 12'd1);
        send_sample(4'd9, 12'd1, 12'd4095);
    endtask

    // The receiver holds off long enough for the block to fill and stall its
    // input while samples keep coming. Then the sender waits for every result
    // before going on.
    task automatic test_backpressure();
        program_setting(realistic_setting());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 1'b1;
        repeat (12)
            send_random_sample();
        wait_until_idle();
        repeat (12)
            send_random_sample();
    endtask

    // Three idle patterns, each under two register sets: sender idles more
    // lightly than the receiver, then the other way round, then neither idles.
    task automatic test_random_traffic();
        int unsigned idle_plan[3][2] = '{'{25, 45}, '{45, 25}, '{0, 0}};
        for (int pattern = 0; pattern < 3; pattern++)
        begin
            for (int half = 0; half < 2; half++)
            begin
                program_setting((pattern == 2 && half == 1) ? wild_setting()
                                                            : realistic_setting());
                send_idle_pct = idle_plan[pattern][0];
                recv_idle_pct = idle_plan[pattern][1];
                repeat (RANDOM_ITEMS_PER_SETTING)
                    send_random_sample();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 1'b0;
        error_count   = 0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            loop_status_of[c] = STAT_OFF;
            last_ohms_of[c]   = '0;
            awaiting_first[c] = 1'b1;
        end
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_rules();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        // Let any stray result item show up before the verdict.
        wait_until_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("fire_loop_resistance_monitor: match");
        else
            $display("fire_loop_resistance_monitor: mismatch");
        $finish;
    end

    // Receiver: random ready at the current idle rate, or one long hold-off
    // when a test asks for it.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_STALL_CYCLES)
                    @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each result item is checked against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result item ch %0d status %0d announce %0d ohms %0d",
                         $time, out_item.channel_out, out_item.loop_status,
                         out_item.announce, out_item.resistance_ohms);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item !== want)
                begin
                    error_count++;
                    $display({"%0t: expected ch %0d status %0d announce %0d ohms %0d,",
                              " actual ch %0d status %0d announce %0d ohms %0d"},
                             $time, want.channel_out, want.loop_status, want.announce,
                             want.resistance_ohms, out_item.channel_out,
                             out_item.loop_status, out_item.announce,
                             out_item.resistance_ohms);
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no item moving on either side means
    // the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("fire_loop_resistance_monitor: mismatch");
            $finish;
        end
    end

endmodule

/* fire_loop_resistance_monitor.f */
src/flrm_pkg.sv
src/flrm_ram.sv
src/flrm_div.sv
src/flrm_rules.sv
src/fire_loop_resistance_monitor.sv
tb/sv/testbench.sv
